// ===== sv/csr_spmv_pkg.sv =====
// ----------------------------------------------------------------------------
// CSR sparse matrix-vector multiply package
// Shared word widths, request codes, result type and output queue sizing.
// ----------------------------------------------------------------------------
`default_nettype none

package csr_spmv_pkg;

  localparam int COL_W = 12;
  localparam int VAL_W = 32;
  localparam int ROW_W = 16;

  localparam int OUT_DEPTH = 8;
  localparam int PTR_W = $clog2(OUT_DEPTH);
  localparam int CNT_W = $clog2(OUT_DEPTH + 1);

  typedef enum logic {
    REQ_LOAD    = 1'b0,
    REQ_NONZERO = 1'b1
  } req_type_t;

  typedef struct packed {
    logic [ROW_W-1:0]        row_index;
    logic signed [VAL_W-1:0] row_sum;
  } result_t;

endpackage

`default_nettype wire

// ===== sv/csr_spmv_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// Simple dual-port synchronous RAM with one write port and a registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module csr_spmv_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== sv/csr_spmv_datapath.sv =====
// ----------------------------------------------------------------------------
// CSR SpMV datapath
// Folds the column into the store, reads or writes the source store, forms
// the product, accumulates the row and converts the finished sum to Q16.16.
// ----------------------------------------------------------------------------
`default_nettype none

module csr_spmv_datapath #(
  parameter int SOURCE_DEPTH = 4096,
  parameter int MAX_ROWS     = 65536
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  input  wire logic                                   word_vld,
  input  wire logic                                   req_type,
  input  wire logic [csr_spmv_pkg::COL_W-1:0]         column,
  input  wire logic signed [csr_spmv_pkg::VAL_W-1:0]  source_value,
  input  wire logic signed [csr_spmv_pkg::VAL_W-1:0]  weight,
  input  wire logic                                   row_end,
  output logic                                        res_vld,
  output csr_spmv_pkg::result_t                       res
);

  localparam int AW = $clog2(SOURCE_DEPTH);
  localparam int CW = csr_spmv_pkg::COL_W;
  localparam int VW = csr_spmv_pkg::VAL_W;
  localparam int RW = csr_spmv_pkg::ROW_W;
  localparam int RECIP_SH = 2 * CW;
  localparam logic [RECIP_SH-1:0] RECIP =
    RECIP_SH'(((64'd1 << RECIP_SH) + 64'(SOURCE_DEPTH) - 64'd1) / 64'(SOURCE_DEPTH));
  localparam bit FOLD = (SOURCE_DEPTH < (1 << CW));
  localparam logic [CW-1:0] DEPTH_LOW = CW'(SOURCE_DEPTH);
  localparam int ROW_WRAP = (MAX_ROWS < (1 << RW)) ? MAX_ROWS : (1 << RW);
  localparam logic [RW:0] ROW_WRAP_V = (RW + 1)'(ROW_WRAP);

  function automatic logic signed [63:0] sat_add64(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
    logic signed [63:0] s;
    s = a + b;
    if ((a[63] == b[63]) && (s[63] != a[63])) begin
      s = a[63] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    end
    return s;
  endfunction

  function automatic logic signed [VW-1:0] to_q16_16(input logic signed [63:0] a);
    logic signed [63:0] sh;
    logic signed [34:0] q;
    logic signed [VW-1:0] r;
    sh = a >>> 30;
    q = 35'(sh) + 35'({34'd0, a[29]});
    if (q > 35'sd2147483647) begin
      r = {1'b0, {(VW-1){1'b1}}};
    end else if (q < -35'sd2147483648) begin
      r = {1'b1, {(VW-1){1'b0}}};
    end else begin
      r = VW'(q);
    end
    return r;
  endfunction

  logic [CW+RECIP_SH-1:0] quo_prod;
  logic [CW-1:0]          quo;

  logic                 s1_vld;
  logic                 s1_nz;
  logic [CW-1:0]        s1_col;
  logic [CW-1:0]        s1_quo;
  logic [VW-1:0]        s1_src;
  logic signed [VW-1:0] s1_wgt;
  logic                 s1_end;
  logic [CW-1:0]        s1_rem;
  logic [AW-1:0]        s1_idx;

  logic                 s2_vld;
  logic signed [VW-1:0] s2_wgt;
  logic                 s2_end;
  logic [VW-1:0]        rd_data;
  logic signed [63:0]   s2_prod;

  logic                 s3_vld;
  logic signed [63:0]   s3_prod;
  logic                 s3_end;
  logic signed [63:0]   acc;
  logic signed [63:0]   acc_next;
  logic                 start_flag;
  logic [RW-1:0]        row_cnt;
  logic [RW:0]          row_inc;
  logic [RW-1:0]        row_cnt_next;

  logic                 s4_vld;
  logic signed [63:0]   s4_acc;
  logic [RW-1:0]        s4_row;

  assign quo_prod = CW'(column) * RECIP;
  assign quo = FOLD ? quo_prod[CW+RECIP_SH-1:RECIP_SH] : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
    end else begin
      s1_vld <= word_vld;
    end
    s1_nz  <= (req_type == csr_spmv_pkg::REQ_NONZERO);
    s1_col <= column;
    s1_quo <= quo;
    s1_src <= source_value;
    s1_wgt <= weight;
    s1_end <= row_end;
  end

  assign s1_rem = s1_col - CW'(s1_quo * DEPTH_LOW);
  assign s1_idx = AW'(s1_rem);

  csr_spmv_ram #(
    .WIDTH(VW),
    .DEPTH(SOURCE_DEPTH)
  ) u_source_ram (
    .clk  (clk),
    .we   (s1_vld && !s1_nz),
    .waddr(s1_idx),
    .wdata(s1_src),
    .re   (s1_vld && s1_nz),
    .raddr(s1_idx),
    .rdata(rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_vld <= 1'b0;
    end else begin
      s2_vld <= s1_vld && s1_nz;
    end
    s2_wgt <= s1_wgt;
    s2_end <= s1_end;
  end

  assign s2_prod = 64'(s2_wgt) * 64'($signed(rd_data));

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_vld <= 1'b0;
    end else begin
      s3_vld <= s2_vld;
    end
    s3_prod <= s2_prod;
    s3_end  <= s2_end;
  end

  assign acc_next = start_flag ? s3_prod : sat_add64(acc, s3_prod);
  assign row_inc = {1'b0, row_cnt} + (RW + 1)'(1);
  assign row_cnt_next = (row_inc >= ROW_WRAP_V) ? '0 : RW'(row_inc);

  always_ff @(posedge clk) begin
    if (rst) begin
      acc        <= '0;
      start_flag <= 1'b1;
      row_cnt    <= '0;
      s4_vld     <= 1'b0;
    end else begin
      s4_vld <= s3_vld && s3_end;
      if (s3_vld) begin
        acc        <= acc_next;
        start_flag <= s3_end;
        if (s3_end) begin
          row_cnt <= row_cnt_next;
        end
      end
    end
    s4_acc <= acc_next;
    s4_row <= row_cnt;
  end

  assign res_vld       = s4_vld;
  assign res.row_index = s4_row;
  assign res.row_sum   = to_q16_16(s4_acc);

`ifndef ASSERT_OFF
  a_row_end_reopens: assert property (@(posedge clk) disable iff (rst)
    (s3_vld && s3_end) |=> (start_flag && s4_vld))
    else $error("row end did not reopen the accumulator");

  a_store_single_access: assert property (@(posedge clk) disable iff (rst)
    s2_vld |-> $past(s1_vld && s1_nz))
    else $error("product stage valid without a store read");
`endif

endmodule

`default_nettype wire

// ===== sv/csr_spmv_fifo.sv =====
// ----------------------------------------------------------------------------
// CSR SpMV result queue
// Small register queue that holds finished rows until the consumer takes them.
// ----------------------------------------------------------------------------
`default_nettype none

module csr_spmv_fifo (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  push,
  input  wire csr_spmv_pkg::result_t push_data,
  input  wire logic                  pop,
  output logic                       out_vld,
  output csr_spmv_pkg::result_t      out_data
);

  localparam int DEPTH = csr_spmv_pkg::OUT_DEPTH;
  localparam int PW    = csr_spmv_pkg::PTR_W;
  localparam int CW    = csr_spmv_pkg::CNT_W;

  csr_spmv_pkg::result_t entries [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          do_pop;

  assign out_vld  = (count != '0);
  assign out_data = entries[rd_ptr];
  assign do_pop   = pop && out_vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PW'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + PW'(1);
      end
      count <= count + CW'(push) - CW'(do_pop);
    end
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> (count < CW'(DEPTH) || do_pop))
    else $error("result queue written while full");
`endif

endmodule

`default_nettype wire

// ===== sv/csr_sparse_matrix_vector_multiply_core.sv =====
// A nonzero row-end word passes registers s1, s2, s3 and s4 and the result queue before it
// is offered. Throughput: one word per cycle, loads and nonzeros alike, with one store access
// and one multiply-accumulate per word; input stalls only while eight results are owed.
// Reset: synchronous and active high; it clears pipeline valids, the accumulator, the row
// number and the result queue. The source store is not cleared and holds garbage until loaded.
// ----------------------------------------------------------------------------
// CSR sparse matrix-vector multiply core
// Top level: input handshake, result credit counter, datapath and result queue.
// ----------------------------------------------------------------------------
`default_nettype none

module csr_sparse_matrix_vector_multiply_core #(
  parameter int SOURCE_DEPTH = 4096,
  parameter int MAX_ROWS     = 65536
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  item_valid,
  output logic                                       item_stall,
  input  wire logic                                  req_type,
  input  wire logic [csr_spmv_pkg::COL_W-1:0]        column,
  input  wire logic signed [csr_spmv_pkg::VAL_W-1:0] source_value,
  input  wire logic signed [csr_spmv_pkg::VAL_W-1:0] weight,
  input  wire logic                                  row_end,
  output logic                                       result_valid,
  input  wire logic                                  result_stall,
  output logic [csr_spmv_pkg::ROW_W-1:0]             row_index,
  output logic signed [csr_spmv_pkg::VAL_W-1:0]      row_sum
);

  localparam int CW = csr_spmv_pkg::CNT_W;

  logic                  word_acc;
  logic                  owes_result;
  logic                  result_acc;
  logic [CW-1:0]         pending;
  logic                  res_vld;
  csr_spmv_pkg::result_t res;
  csr_spmv_pkg::result_t out_data;

  assign item_stall  = (pending == CW'(csr_spmv_pkg::OUT_DEPTH));
  assign word_acc    = item_valid && !item_stall;
  assign owes_result = word_acc && (req_type == csr_spmv_pkg::REQ_NONZERO) && row_end;
  assign result_acc  = result_valid && !result_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else begin
      pending <= pending + CW'(owes_result) - CW'(result_acc);
    end
  end

  csr_spmv_datapath #(
    .SOURCE_DEPTH(SOURCE_DEPTH),
    .MAX_ROWS    (MAX_ROWS)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .word_vld    (word_acc),
    .req_type    (req_type),
    .column      (column),
    .source_value(source_value),
    .weight      (weight),
    .row_end     (row_end),
    .res_vld     (res_vld),
    .res         (res)
  );

  csr_spmv_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (res_vld),
    .push_data(res),
    .pop      (result_acc),
    .out_vld  (result_valid),
    .out_data (out_data)
  );

  assign row_index = out_data.row_index;
  assign row_sum   = out_data.row_sum;

`ifndef ASSERT_OFF
  a_credit_bound: assert property (@(posedge clk) disable iff (rst)
    pending <= CW'(csr_spmv_pkg::OUT_DEPTH))
    else $error("result credit count exceeds queue depth");

  a_result_owed: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (pending != '0))
    else $error("result offered with no row-end word outstanding");
`endif

endmodule

`default_nettype wire

// ===== tb/sv/csr_spmv_scoreboard_pkg.sv =====
// ----------------------------------------------------------------------------
// CSR sparse matrix-vector multiply scoreboard
// Predicts row sums from accepted words and checks each result word in order.
// ----------------------------------------------------------------------------
`default_nettype none

package csr_spmv_scoreboard_pkg;

  localparam int     STORE_DEPTH = 4096;
  localparam int     ROW_LIMIT   = 65536;
  localparam longint ACC_MAX     = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam longint ACC_MIN     = 64'sh8000_0000_0000_0000;
  localparam longint Q_MAX       = 64'sd2147483647;
  localparam longint Q_MIN       = -64'sd2147483648;

  class spmv_scoreboard;

    bit [csr_spmv_pkg::VAL_W-1:0] source_mem [STORE_DEPTH];
    longint                       acc;
    bit [csr_spmv_pkg::ROW_W-1:0] row_num;
    bit                           row_open;
    csr_spmv_pkg::result_t        owed [$];
    int                           fails;

    function new();
      acc = 0;
      row_num = '0;
      row_open = 1'b0;
      fails = 0;
    endfunction

    task report_mismatch(string msg);
      $display("MISMATCH at %0t: %s", $time, msg);
      fails++;
    endtask

    function longint sat_add(longint a, longint b);
      longint s;
      s = a + b;
      if (a[63] == b[63] && s[63] != a[63]) begin
        s = a[63] ? ACC_MIN : ACC_MAX;
      end
      return s;
    endfunction

    // Q18.46 to Q16.16, rounding half up, then clamped to 32 bits.
    function bit [csr_spmv_pkg::VAL_W-1:0] to_q16(longint a);
      longint q;
      q = a >>> 30;
      if (a[29]) begin
        q = q + 1;
      end
      if (q > Q_MAX) begin
        q = Q_MAX;
      end else if (q < Q_MIN) begin
        q = Q_MIN;
      end
      return q[csr_spmv_pkg::VAL_W-1:0];
    endfunction

    function void note_word(csr_spmv_pkg::req_type_t kind,
                            bit [csr_spmv_pkg::COL_W-1:0] col,
                            bit [csr_spmv_pkg::VAL_W-1:0] sval,
                            bit [csr_spmv_pkg::VAL_W-1:0] wt, bit last);
      longint                prod;
      csr_spmv_pkg::result_t r;
      int                    nxt;
      if (kind == csr_spmv_pkg::REQ_LOAD) begin
        source_mem[col] = sval;
        return;
      end
      prod = longint'($signed(wt)) * longint'($signed(source_mem[col]));
      acc = row_open ? sat_add(acc, prod) : prod;
      row_open = !last;
      if (last) begin
        r.row_index = row_num;
        r.row_sum = to_q16(acc);
        owed.push_back(r);
        nxt = int'(row_num) + 1;
        if (nxt >= ROW_LIMIT) begin
          nxt = 0;
        end
        row_num = nxt[csr_spmv_pkg::ROW_W-1:0];
      end
    endfunction

    task check_row(logic [csr_spmv_pkg::ROW_W-1:0] idx, logic [csr_spmv_pkg::VAL_W-1:0] sum);
      csr_spmv_pkg::result_t w;
      if (owed.size() == 0) begin
        report_mismatch($sformatf("unexpected row %0d with sum %h", idx, sum));
        return;
      end
      w = owed.pop_front();
      if (idx !== w.row_index) begin
        report_mismatch($sformatf("row_index %h, expected %h", idx, w.row_index));
      end
      if (sum !== w.row_sum) begin
        report_mismatch($sformatf("row %0d row_sum %h, expected %h", w.row_index, sum,
                                  w.row_sum));
      end
    endtask

    function int pending();
      return owed.size();
    endfunction

  endclass

endpackage

`default_nettype wire

// ===== tb/sv/csr_sparse_matrix_vector_multiply_core_test.sv =====
// ----------------------------------------------------------------------------
// CSR sparse matrix-vector multiply core test
// Streams source loads and matrix rows through the core with random idling on
// both sides, predicts every row sum and checks the result words in order.
// ----------------------------------------------------------------------------
`default_nettype none

module csr_sparse_matrix_vector_multiply_core_test;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int LATENCY        = 4;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int COL_W          = csr_spmv_pkg::COL_W;
  localparam int VAL_W          = csr_spmv_pkg::VAL_W;
  localparam int ROW_W          = csr_spmv_pkg::ROW_W;

  logic                    clk;
  logic                    rst          = 1'b1;
  logic                    item_valid   = 1'b0;
  logic                    item_stall;
  logic                    req_type     = csr_spmv_pkg::REQ_LOAD;
  logic [COL_W-1:0]        column       = '0;
  logic signed [VAL_W-1:0] source_value = '0;
  logic signed [VAL_W-1:0] weight       = '0;
  logic                    row_end      = 1'b0;
  logic                    result_valid;
  logic                    result_stall = 1'b0;
  logic [ROW_W-1:0]        row_index;
  logic signed [VAL_W-1:0] row_sum;

  csr_spmv_scoreboard_pkg::spmv_scoreboard sb;
  int               tx_idle = 0;
  int               rx_idle = 0;
  int unsigned      words_sent = 0;
  int               quiet = 0;
  bit               loaded [csr_spmv_scoreboard_pkg::STORE_DEPTH];
  bit [COL_W-1:0]   loaded_cols [$];
  bit [COL_W-1:0]   last_load = '0;

  csr_sparse_matrix_vector_multiply_core u_dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .req_type     (req_type),
    .column       (column),
    .source_value (source_value),
    .weight       (weight),
    .row_end      (row_end),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .row_index    (row_index),
    .row_sum      (row_sum)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    result_stall <= !rst && ($urandom_range(99) < rx_idle);
  end

  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) begin
      sb.check_row(row_index, row_sum);
    end
  end

  always @(posedge clk) begin
    if (rst || (item_valid && !item_stall) || (result_valid && !result_stall)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
    end
  end

  initial begin
    while (quiet < WATCHDOG_LIMIT) @(posedge clk);
    $display("== FAIL ==");
    $finish;
  end

  function automatic bit [VAL_W-1:0] rand_q();
    bit [31:0] r;
    r = $urandom;
    unique case ($urandom_range(9))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return 32'h0000_0000;
      3, 4, 5: return {{12{r[19]}}, r[19:0]};
      6, 7:    return {{2{r[29]}}, r[29:0]};
      default: return r;
    endcase
  endfunction

  function automatic bit [COL_W-1:0] pick_col();
    return loaded_cols[$urandom_range(loaded_cols.size() - 1)];
  endfunction

  task automatic send_word(input csr_spmv_pkg::req_type_t kind, input bit [COL_W-1:0] col,
                           input bit [VAL_W-1:0] sval, input bit [VAL_W-1:0] wt,
                           input bit last);
    while ($urandom_range(99) < tx_idle) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid   <= 1'b1;
    req_type     <= kind;
    column       <= col;
    source_value <= sval;
    weight       <= wt;
    row_end      <= last;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    sb.note_word(kind, col, sval, wt, last);
    words_sent++;
  endtask

  task automatic load_col(input bit [COL_W-1:0] col, input bit [VAL_W-1:0] v);
    send_word(csr_spmv_pkg::REQ_LOAD, col, v, $urandom, 1'($urandom_range(1)));
    if (!loaded[col]) begin
      loaded[col] = 1'b1;
      loaded_cols.push_back(col);
    end
    last_load = col;
  endtask

  task automatic nonzero(input bit [COL_W-1:0] col, input bit [VAL_W-1:0] wt,
                         input bit last);
    send_word(csr_spmv_pkg::REQ_NONZERO, col, $urandom, wt, last);
  endtask

  task automatic run_rows(input int unsigned target);
    int unsigned    start;
    int unsigned    nnz;
    bit [COL_W-1:0] col;
    start = words_sent;
    while (words_sent - start < target) begin
      nnz = ($urandom_range(7) == 0) ? $urandom_range(7, 16) : $urandom_range(1, 4);
      repeat ($urandom_range(2)) load_col(COL_W'($urandom_range(4095)), rand_q());
      for (int k = 0; k < nnz; k++) begin
        if ($urandom_range(9) == 0) begin
          load_col(($urandom_range(1) == 0) ? pick_col() : COL_W'($urandom_range(4095)),
                   rand_q());
        end
        col = ($urandom_range(5) == 0) ? last_load : pick_col();
        nonzero(col, rand_q(), k == nnz - 1);
      end
    end
  endtask

  initial begin
    sb = new();
    tx_idle = 29;
    rx_idle = 62;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed words: extreme products, accumulator saturation in both
    // directions, rounding ties on both signs, a load in the middle of a row
    // that the same row then reads, and a zero weight.
    load_col(12'd0, 32'h7FFF_FFFF);
    load_col(12'd4095, 32'h8000_0000);
    load_col(12'd1, 32'h0001_0000);
    load_col(12'd2, 32'hFFFF_0000);
    load_col(12'hAAA, 32'h0000_0001);
    load_col(12'h555, 32'hFFFF_FFFF);
    nonzero(12'd0, 32'h7FFF_FFFF, 1'b1);
    nonzero(12'd4095, 32'h8000_0000, 1'b1);
    repeat (2) nonzero(12'd0, 32'h7FFF_FFFF, 1'b0);
    nonzero(12'd0, 32'h7FFF_FFFF, 1'b1);
    repeat (2) nonzero(12'd4095, 32'h7FFF_FFFF, 1'b0);
    nonzero(12'd4095, 32'h7FFF_FFFF, 1'b1);
    nonzero(12'hAAA, 32'h2000_0000, 1'b1);
    nonzero(12'hAAA, 32'hE000_0000, 1'b1);
    nonzero(12'd1, 32'h4000_0000, 1'b0);
    load_col(12'd2, 32'h0003_0000);
    nonzero(12'd2, 32'h4000_0000, 1'b1);
    nonzero(12'h555, 32'h0000_0000, 1'b1);

    run_rows(135);
    tx_idle = 62;
    rx_idle = 29;
    run_rows(135);
    tx_idle = 0;
    rx_idle = 0;
    run_rows(130);
    item_valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (4 * LATENCY) @(posedge clk);
    if (sb.fails == 0 && sb.pending() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

`default_nettype wire
